// ----- rtl/core/spi_pkg.sv -----
// Shared types and constants for the segment pair intersection block.
`timescale 1ns / 1ps

package spi_pkg;

	localparam int SPI_UNIT_FRAC_BITS = 30;
	localparam int SPI_LAT_BASE = 94;
	localparam int EPS_W = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

	typedef enum logic [1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_PARALLEL = 2'd2,
		ST_DEGEN    = 2'd3
	} status_t;

	typedef struct packed {
		logic signed [31:0] a_start_x;
		logic signed [31:0] a_start_y;
		logic signed [31:0] a_end_x;
		logic signed [31:0] a_end_y;
		logic signed [31:0] b_start_x;
		logic signed [31:0] b_start_y;
		logic signed [31:0] b_end_x;
		logic signed [31:0] b_end_y;
	} seg_in_t;

	typedef struct packed {
		status_t            status;
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
		logic signed [47:0] dist_along_a;
		logic signed [47:0] dist_along_b;
		logic [32:0]        mid_distance;
	} seg_out_t;

endpackage

// ----- rtl/core/segment_pair_intersection_top.sv -----
// Top level of the segment pair intersection block: a fully pipelined datapath.
`timescale 1ns / 1ps

// The block takes one segment pair in every clock cycle and never raises busy. Each result is
// strobed on done in the order of acceptance; the receiver must take it in that cycle. The
// datapath is built from bit-per-stage pipelines: 34 stages for the square roots, UNIT_FRAC_BITS
// + 1 for the unit vector divisions and 48 for the divisions that give t and u. The epsilon word
// may only be written while no pair is in flight; its write channel is always ready.
module segment_pair_intersection_top import spi_pkg::*; #(
	parameter int UNIT_FRAC_BITS = SPI_UNIT_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  seg_in_t          pair,
	output logic             done,
	output seg_out_t         result,
	input  logic             eps_valid,
	output logic             eps_ready,
	input  logic [EPS_W-1:0] eps_data
);

	localparam int F      = UNIT_FRAC_BITS;
	localparam int UW     = F + 2;
	localparam int QW     = F + 1;
	localparam int UR     = 35;
	localparam int RTW    = 34;
	localparam int SQW    = 2 * RTW;
	localparam int REMW   = RTW + 2;
	localparam int PW     = 2 * UW;
	localparam int DTW    = 2 * F + 3;
	localparam int NTW    = F + 35;
	localparam int NMW    = 2 * F + 34;
	localparam int DDW    = 2 * F + 2;
	localparam int RW     = 2 * F + 3;
	localparam int CW     = 2 * F + 50;
	localparam int QDW    = 48;
	localparam int CLW    = 25 + UW;
	localparam int CHW    = 24 + UW;
	localparam int MXW    = QDW + UW;
	localparam int VW     = 50;
	localparam int THR_SH = F - 16;

	localparam int S_RT  = 3;
	localparam int S_UN  = S_RT + RTW;
	localparam int S_THR = S_UN + QW;
	localparam int S_MUL = S_THR + 1;
	localparam int S_DOT = S_MUL + 1;
	localparam int S_PRE = S_DOT + 1;
	localparam int S_DIV = S_PRE + 1;
	localparam int S_CLP = S_DIV + QDW;
	localparam int S_CM  = S_CLP + 1;
	localparam int S_CS  = S_CM + 1;
	localparam int S_OUT = S_CS + 1;
	localparam int NS    = S_OUT + 1;

	typedef struct packed {
		logic signed [32:0]    dax;
		logic signed [32:0]    day;
		logic signed [32:0]    dbx;
		logic signed [32:0]    dby;
		logic signed [32:0]    ex;
		logic signed [32:0]    ey;
		logic signed [31:0]    ax;
		logic signed [31:0]    ay;
		logic [RTW-1:0]        len_a;
		logic [RTW-1:0]        len_b;
		logic [32:0]           mdist;
		logic                  degen;
		logic                  par;
		logic signed [UW-1:0]  uax;
		logic signed [UW-1:0]  uay;
		logic signed [UW-1:0]  ubx;
		logic signed [UW-1:0]  uby;
		logic [1:0]            neg;
		logic [1:0]            ovf;
		logic signed [QDW-1:0] t;
		logic signed [QDW-1:0] u;
	} ctx_t;

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		return v[33] ? 34'(-v) : 34'(v);
	endfunction

	function automatic logic signed [32:0] delta_of(input ctx_t c, input int unsigned l);
		logic signed [32:0] d;
		case (l)
			0:       d = c.dax;
			1:       d = c.day;
			2:       d = c.dbx;
			default: d = c.dby;
		endcase
		return d;
	endfunction

	function automatic logic signed [31:0] sat_cut(input logic signed [VW-1:0] v,
			input logic [EPS_W-1:0] eps);
		logic signed [31:0] s;
		logic [32:0]        m;
		if (v[VW-1:31] != {(VW - 31){v[31]}}) begin
			s = v[VW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			s = v[31:0];
		end
		m = s[31] ? 33'(-33'(s)) : 33'(s);
		return (m < 33'(eps)) ? 32'sd0 : s;
	endfunction

	logic [EPS_W-1:0]      eps_q;
	logic [NS-1:0]         vld_s;
	ctx_t                  ctx_s [NS];
	ctx_t                  ctx_nx [NS];
	logic signed [33:0]    mx0, my0, mx_s1, my_s1;
	logic [SQW-1:0]        sq_s2 [6];
	logic [SQW-1:0]        op_s3 [3];
	logic [REMW-1:0]       rt_rem [3][RTW];
	logic [RTW-1:0]        rt_root [3][RTW];
	logic [SQW-1:0]        rt_op [3][RTW];
	logic [UR-1:0]         un_r [4][QW];
	logic [QW-1:0]         un_q [4][QW];
	logic signed [UW-1:0]  uv [4];
	logic signed [PW-1:0]  pa_s, pb_s, dsum;
	logic signed [NTW-1:0] na_s, nb_s, ma_s, mb_s;
	logic signed [DTW-1:0] dt_s;
	logic signed [NTW-1:0] nt_s, nu_s;
	logic [RW-1:0]         pre_rem [2];
	logic [QDW-1:0]        pre_low [2];
	logic [DDW-1:0]        pre_d [2];
	logic [1:0]            pre_neg, pre_ovf;
	logic [RW-1:0]         dv_rem [2][QDW+1];
	logic [QDW-1:0]        dv_low [2][QDW+1];
	logic [QDW-1:0]        dv_q [2][QDW+1];
	logic [DDW-1:0]        dv_d [2][QDW+1];
	logic signed [QDW-1:0] tv [2];
	logic signed [CLW-1:0] cxl_s, cyl_s;
	logic signed [CHW-1:0] cxh_s, cyh_s;
	logic signed [VW-1:0]  cvx, cvy, cvx_s, cvy_s;
	seg_out_t              res_nx, res_s;

	assign busy      = 1'b0;
	assign eps_ready = 1'b1;
	assign done      = vld_s[NS-1];
	assign result    = res_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			vld_s <= '0;
		end else begin
			if (eps_valid) begin
				eps_q <= eps_data;
			end
			vld_s <= {vld_s[NS-2:0], start};
		end
	end

	always_comb begin
		mx0 = 34'(pair.a_start_x) + 34'(pair.a_end_x) - 34'(pair.b_start_x) - 34'(pair.b_end_x);
		my0 = 34'(pair.a_start_y) + 34'(pair.a_end_y) - 34'(pair.b_start_y) - 34'(pair.b_end_y);
	end

	always_comb begin
		for (int k = 1; k < NS; k++) begin
			ctx_nx[k] = ctx_s[k-1];
		end
		ctx_nx[0]     = '0;
		ctx_nx[0].dax = 33'(pair.a_end_x) - 33'(pair.a_start_x);
		ctx_nx[0].day = 33'(pair.a_end_y) - 33'(pair.a_start_y);
		ctx_nx[0].dbx = 33'(pair.b_end_x) - 33'(pair.b_start_x);
		ctx_nx[0].dby = 33'(pair.b_end_y) - 33'(pair.b_start_y);
		ctx_nx[0].ex  = 33'(pair.b_start_x) - 33'(pair.a_start_x);
		ctx_nx[0].ey  = 33'(pair.b_start_y) - 33'(pair.a_start_y);
		ctx_nx[0].ax  = pair.a_start_x;
		ctx_nx[0].ay  = pair.a_start_y;

		ctx_nx[S_UN].len_a = rt_root[0][RTW-1];
		ctx_nx[S_UN].len_b = rt_root[1][RTW-1];
		ctx_nx[S_UN].mdist = 33'(rt_root[2][RTW-1] >> 1);
		ctx_nx[S_UN].degen = (rt_root[0][RTW-1] == '0) || (rt_root[1][RTW-1] == '0);

		ctx_nx[S_THR].uax = uv[0];
		ctx_nx[S_THR].uay = uv[1];
		ctx_nx[S_THR].ubx = uv[2];
		ctx_nx[S_THR].uby = uv[3];

		ctx_nx[S_DOT].par = (dsum == '0);

		ctx_nx[S_PRE].neg = pre_neg;
		ctx_nx[S_PRE].ovf = pre_ovf;

		ctx_nx[S_CLP].t = tv[0];
		ctx_nx[S_CLP].u = tv[1];
	end

	always_ff @(posedge clk) begin
		ctx_s <= ctx_nx;
		mx_s1 <= mx0;
		my_s1 <= my0;
		sq_s2[0] <= SQW'(mag34(34'(ctx_s[0].dax))) * SQW'(mag34(34'(ctx_s[0].dax)));
		sq_s2[1] <= SQW'(mag34(34'(ctx_s[0].day))) * SQW'(mag34(34'(ctx_s[0].day)));
		sq_s2[2] <= SQW'(mag34(34'(ctx_s[0].dbx))) * SQW'(mag34(34'(ctx_s[0].dbx)));
		sq_s2[3] <= SQW'(mag34(34'(ctx_s[0].dby))) * SQW'(mag34(34'(ctx_s[0].dby)));
		sq_s2[4] <= SQW'(mag34(mx_s1)) * SQW'(mag34(mx_s1));
		sq_s2[5] <= SQW'(mag34(my_s1)) * SQW'(mag34(my_s1));
		op_s3[0] <= sq_s2[0] + sq_s2[1];
		op_s3[1] <= sq_s2[2] + sq_s2[3];
		op_s3[2] <= sq_s2[4] + sq_s2[5];
	end

	// Square roots, one root bit per stage.
	for (genvar k = 0; k < RTW; k++) begin : g_rt
		for (genvar l = 0; l < 3; l++) begin : g_ln
			logic [REMW-1:0] rem_i, rr, trial;
			logic [RTW-1:0]  root_i;
			logic [SQW-1:0]  op_i;
			if (k == 0) begin : g_first
				assign rem_i  = '0;
				assign root_i = '0;
				assign op_i   = op_s3[l];
			end else begin : g_next
				assign rem_i  = rt_rem[l][k-1];
				assign root_i = rt_root[l][k-1];
				assign op_i   = rt_op[l][k-1];
			end
			assign rr    = {rem_i[REMW-3:0], op_i[SQW-1 -: 2]};
			assign trial = {root_i, 2'b01};
			always_ff @(posedge clk) begin
				if (rr >= trial) begin
					rt_rem[l][k]  <= rr - trial;
					rt_root[l][k] <= {root_i[RTW-2:0], 1'b1};
				end else begin
					rt_rem[l][k]  <= rr;
					rt_root[l][k] <= {root_i[RTW-2:0], 1'b0};
				end
				rt_op[l][k] <= op_i << 2;
			end
		end
	end

	// Unit vector components, one quotient bit per stage.
	for (genvar j = 0; j < QW; j++) begin : g_un
		for (genvar l = 0; l < 4; l++) begin : g_ln
			logic [UR-1:0] rr, dd;
			logic [QW-1:0] qi;
			if (j == 0) begin : g_first
				assign rr = UR'(mag34(34'(delta_of(ctx_s[S_UN-1], l))));
				assign dd = UR'(rt_root[(l < 2) ? 0 : 1][RTW-1]);
				assign qi = '0;
			end else begin : g_next
				assign rr = {un_r[l][j-1][UR-2:0], 1'b0};
				assign dd = UR'((l < 2) ? ctx_s[S_UN+j-1].len_a : ctx_s[S_UN+j-1].len_b);
				assign qi = un_q[l][j-1];
			end
			always_ff @(posedge clk) begin
				if (rr >= dd) begin
					un_r[l][j] <= rr - dd;
					un_q[l][j] <= {qi[QW-2:0], 1'b1};
				end else begin
					un_r[l][j] <= rr;
					un_q[l][j] <= {qi[QW-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		logic [QW-1:0] thr;
		logic [QW-1:0] q;
		thr = QW'(eps_q) << THR_SH;
		for (int l = 0; l < 4; l++) begin
			q = un_q[l][QW-1];
			if (q < thr) begin
				uv[l] = '0;
			end else if (delta_of(ctx_s[S_THR-1], l) < 0) begin
				uv[l] = -UW'(q);
			end else begin
				uv[l] = UW'(q);
			end
		end
	end

	assign dsum = pa_s + pb_s;

	always_ff @(posedge clk) begin
		pa_s <= PW'(ctx_s[S_THR].uax) * PW'(-ctx_s[S_THR].uby);
		pb_s <= PW'(ctx_s[S_THR].uay) * PW'(ctx_s[S_THR].ubx);
		na_s <= NTW'(ctx_s[S_THR].ex) * NTW'(-ctx_s[S_THR].uby);
		nb_s <= NTW'(ctx_s[S_THR].ey) * NTW'(ctx_s[S_THR].ubx);
		ma_s <= NTW'(ctx_s[S_THR].ex) * NTW'(ctx_s[S_THR].uay);
		mb_s <= NTW'(-ctx_s[S_THR].ey) * NTW'(ctx_s[S_THR].uax);
		dt_s <= DTW'(dsum);
		nt_s <= na_s + nb_s;
		nu_s <= ma_s + mb_s;
	end

	// The denominator for u is the negated denominator for t.
	always_comb begin
		logic signed [NTW-1:0] n;
		logic                  dneg;
		logic [NTW-1:0]        mn;
		logic [DDW-1:0]        md;
		logic [NMW-1:0]        nn;
		for (int l = 0; l < 2; l++) begin
			n    = (l == 0) ? nt_s : nu_s;
			dneg = (l == 0) ? dt_s[DTW-1] : ((dt_s != '0) && !dt_s[DTW-1]);
			mn   = n[NTW-1] ? NTW'(-n) : NTW'(n);
			md   = dt_s[DTW-1] ? DDW'(-dt_s) : DDW'(dt_s);
			nn   = NMW'(mn) << F;
			pre_ovf[l] = CW'(nn) >= (CW'(md) << QDW);
			pre_neg[l] = n[NTW-1] != dneg;
			pre_rem[l] = RW'(nn >> QDW);
			pre_low[l] = nn[QDW-1:0];
			pre_d[l]   = md;
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_dv_ld
		always_ff @(posedge clk) begin
			dv_rem[l][0] <= pre_rem[l];
			dv_low[l][0] <= pre_low[l];
			dv_q[l][0]   <= '0;
			dv_d[l][0]   <= pre_d[l];
		end
	end

	// Division for t and u, one quotient bit per stage.
	for (genvar k = 1; k <= QDW; k++) begin : g_dv
		for (genvar l = 0; l < 2; l++) begin : g_ln
			logic [RW-1:0] rr;
			assign rr = {dv_rem[l][k-1][RW-2:0], dv_low[l][k-1][QDW-1]};
			always_ff @(posedge clk) begin
				if (rr >= RW'(dv_d[l][k-1])) begin
					dv_rem[l][k] <= rr - RW'(dv_d[l][k-1]);
					dv_q[l][k]   <= {dv_q[l][k-1][QDW-2:0], 1'b1};
				end else begin
					dv_rem[l][k] <= rr;
					dv_q[l][k]   <= {dv_q[l][k-1][QDW-2:0], 1'b0};
				end
				dv_low[l][k] <= dv_low[l][k-1] << 1;
				dv_d[l][k]   <= dv_d[l][k-1];
			end
		end
	end

	always_comb begin
		logic [QDW-1:0] q;
		logic [QDW-1:0] lim;
		for (int l = 0; l < 2; l++) begin
			q   = dv_q[l][QDW];
			lim = ctx_s[S_CLP-1].neg[l] ? {1'b1, {(QDW - 1){1'b0}}} : {1'b0, {(QDW - 1){1'b1}}};
			if (ctx_s[S_CLP-1].ovf[l] || (q > lim)) begin
				q = lim;
			end
			tv[l] = ctx_s[S_CLP-1].neg[l] ? -QDW'(q) : QDW'(q);
		end
	end

	always_ff @(posedge clk) begin
		cxl_s <= CLW'($signed({1'b0, ctx_s[S_CLP].t[23:0]})) * CLW'(ctx_s[S_CLP].uax);
		cxh_s <= CHW'($signed(ctx_s[S_CLP].t[47:24])) * CHW'(ctx_s[S_CLP].uax);
		cyl_s <= CLW'($signed({1'b0, ctx_s[S_CLP].t[23:0]})) * CLW'(ctx_s[S_CLP].uay);
		cyh_s <= CHW'($signed(ctx_s[S_CLP].t[47:24])) * CHW'(ctx_s[S_CLP].uay);
	end

	always_comb begin
		logic signed [MXW-1:0] px, py;
		px  = (MXW'(cxh_s) <<< 24) + MXW'(cxl_s);
		py  = (MXW'(cyh_s) <<< 24) + MXW'(cyl_s);
		px  = px >>> F;
		py  = py >>> F;
		cvx = VW'(px) + VW'(ctx_s[S_CS-1].ax);
		cvy = VW'(py) + VW'(ctx_s[S_CS-1].ay);
	end

	always_ff @(posedge clk) begin
		cvx_s <= cvx;
		cvy_s <= cvy;
	end

	always_comb begin
		ctx_t c;
		logic hit;
		c   = ctx_s[S_OUT-1];
		hit = (c.t > 0) && ($unsigned(c.t) <= QDW'(c.len_a))
			&& (c.u > 0) && ($unsigned(c.u) <= QDW'(c.len_b));
		res_nx              = '0;
		res_nx.mid_distance = c.mdist;
		if (c.degen) begin
			res_nx.status = ST_DEGEN;
		end else if (c.par) begin
			res_nx.status = ST_PARALLEL;
		end else begin
			res_nx.status       = hit ? ST_HIT : ST_MISS;
			res_nx.cross_x      = sat_cut(cvx_s, eps_q);
			res_nx.cross_y      = sat_cut(cvy_s, eps_q);
			res_nx.dist_along_a = c.t;
			res_nx.dist_along_b = c.u;
		end
	end

	always_ff @(posedge clk) begin
		res_s <= res_nx;
	end

endmodule

// ----- rtl/core/spi_chk.sv -----
// Port checker for the segment pair intersection block and its bind statement.
`timescale 1ns / 1ps

module spi_chk import spi_pkg::*; #(
	parameter int UNIT_FRAC_BITS = SPI_UNIT_FRAC_BITS
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input seg_in_t          pair,
	input logic             done,
	input seg_out_t         result,
	input logic             eps_valid,
	input logic             eps_ready,
	input logic [EPS_W-1:0] eps_data
);

	localparam int LAT  = UNIT_FRAC_BITS + SPI_LAT_BASE;
	localparam int CNTW = $clog2(LAT + 1);

	logic [CNTW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CNTW'(LAT)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted word gave no result at the fixed latency");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (cnt_q == CNTW'(LAT)) && $past(start && !busy, LAT))
		else $error("result strobed without a matching accepted word");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_DEGEN || result.status == ST_PARALLEL)
		|-> result.cross_x == '0 && result.cross_y == '0
			&& result.dist_along_a == '0 && result.dist_along_b == '0)
		else $error("parallel or degenerate result carries nonzero values");

	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_HIT
		|-> result.dist_along_a > 0 && result.dist_along_b > 0)
		else $error("intersection reported with non-positive distance");

endmodule

bind segment_pair_intersection_top spi_chk #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_spi_chk (.*);

// ----- bench/segment_pair_intersection_top_tb.sv -----
// Self-checking testbench for the segment pair intersection block.
`timescale 1ns / 1ps

module segment_pair_intersection_top_tb;
	import spi_pkg::*;

	localparam int FB = SPI_UNIT_FRAC_BITS;
	localparam int LATENCY = FB + SPI_LAT_BASE;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_PER_PHASE = 160;

	class intersect_scoreboard;
		seg_out_t expected_crossings[$];
		logic [EPS_W-1:0] eps;
		int errors;

		function new();
			eps = EPS_RESET;
			errors = 0;
		endfunction

		static function logic [35:0] isqrt(logic [127:0] s);
			logic [35:0] r;
			logic [35:0] c;
			r = '0;
			for (int b = 35; b >= 0; b--) begin
				c = r | (36'd1 << b);
				if (128'(c) * 128'(c) <= s) r = c;
			end
			return r;
		endfunction

		function logic signed [127:0] unit_part(logic signed [127:0] v, logic [35:0] len);
			logic [127:0] m;
			logic [127:0] q;
			logic [127:0] thr;
			m = (v < 0) ? -v : v;
			q = (m << FB) / 128'(len);
			thr = 128'(eps) << (FB - 16);
			if (q < thr) return '0;
			return (v < 0) ? -$signed(q) : $signed(q);
		endfunction

		static function logic signed [127:0] scaled_div(logic signed [127:0] n,
				logic signed [127:0] d);
			logic neg;
			logic [191:0] an;
			logic [191:0] ad;
			logic [191:0] q;
			logic [191:0] limit;
			neg = (n < 0) != (d < 0);
			an = (n < 0) ? 192'(-n) : 192'(n);
			ad = (d < 0) ? 192'(-d) : 192'(d);
			q = (an << FB) / ad;
			limit = neg ? (192'd1 << 47) : ((192'd1 << 47) - 1);
			if (q > limit) q = limit;
			return neg ? -$signed(128'(q)) : $signed(128'(q));
		endfunction

		function logic signed [127:0] cross_at(logic signed [127:0] p0,
				logic signed [127:0] t, logic signed [127:0] uc);
			logic signed [127:0] m;
			logic signed [127:0] v;
			logic signed [127:0] mv;
			m = t * uc;
			v = p0 + (m >>> FB);
			if (v > 128'sd2147483647) v = 128'sd2147483647;
			if (v < -128'sd2147483648) v = -128'sd2147483648;
			mv = (v < 0) ? -v : v;
			if (mv < 128'(eps)) v = '0;
			return v;
		endfunction

		function seg_out_t predict_crossing(seg_in_t p);
			logic signed [127:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
			logic signed [127:0] dax, day, dbx, dby, mx, my;
			logic signed [127:0] uax, uay, ubx, uby, dt, du, t, u, cx, cy;
			logic [35:0] lena, lenb, md;
			seg_out_t r;
			ax0 = p.a_start_x; ay0 = p.a_start_y; ax1 = p.a_end_x; ay1 = p.a_end_y;
			bx0 = p.b_start_x; by0 = p.b_start_y; bx1 = p.b_end_x; by1 = p.b_end_y;
			dax = ax1 - ax0; day = ay1 - ay0; dbx = bx1 - bx0; dby = by1 - by0;
			mx = (ax0 + ax1) - (bx0 + bx1);
			my = (ay0 + ay1) - (by0 + by1);
			lena = isqrt(dax * dax + day * day);
			lenb = isqrt(dbx * dbx + dby * dby);
			md = isqrt(mx * mx + my * my) >> 1;
			if (md > 36'h1_FFFF_FFFF) md = 36'h1_FFFF_FFFF;
			r = '0;
			r.mid_distance = md[32:0];
			if (lena == 0 || lenb == 0) begin
				r.status = ST_DEGEN;
			end else begin
				uax = unit_part(dax, lena); uay = unit_part(day, lena);
				ubx = unit_part(dbx, lenb); uby = unit_part(dby, lenb);
				dt = uax * (-uby) + uay * ubx;
				du = ubx * (-uay) + uby * uax;
				if (dt == 0 || du == 0) begin
					r.status = ST_PARALLEL;
				end else begin
					t = scaled_div((bx0 - ax0) * (-uby) + (by0 - ay0) * ubx, dt);
					u = scaled_div((ax0 - bx0) * (-uay) + (ay0 - by0) * uax, du);
					cx = cross_at(ax0, t, uax);
					cy = cross_at(ay0, t, uay);
					r.cross_x = cx[31:0];
					r.cross_y = cy[31:0];
					r.dist_along_a = t[47:0];
					r.dist_along_b = u[47:0];
					if (t > 0 && t <= $signed(128'(lena)) && u > 0
							&& u <= $signed(128'(lenb)))
						r.status = ST_HIT;
					else
						r.status = ST_MISS;
				end
			end
			return r;
		endfunction

		function void note_pair(seg_in_t p);
			expected_crossings.push_back(predict_crossing(p));
		endfunction

		function void check_result(seg_out_t got);
			seg_out_t exp_r;
			if (expected_crossings.size() == 0) begin
				$error("result word with no pair outstanding");
				errors++;
				return;
			end
			exp_r = expected_crossings.pop_front();
			if (got.status !== exp_r.status) begin
				$error("status: expected %0d, actual %0d", exp_r.status, got.status);
				errors++;
			end
			if (got.cross_x !== exp_r.cross_x) begin
				$error("cross_x: expected %0d, actual %0d", exp_r.cross_x, got.cross_x);
				errors++;
			end
			if (got.cross_y !== exp_r.cross_y) begin
				$error("cross_y: expected %0d, actual %0d", exp_r.cross_y, got.cross_y);
				errors++;
			end
			if (got.dist_along_a !== exp_r.dist_along_a) begin
				$error("dist_along_a: expected %0d, actual %0d", exp_r.dist_along_a,
					got.dist_along_a);
				errors++;
			end
			if (got.dist_along_b !== exp_r.dist_along_b) begin
				$error("dist_along_b: expected %0d, actual %0d", exp_r.dist_along_b,
					got.dist_along_b);
				errors++;
			end
			if (got.mid_distance !== exp_r.mid_distance) begin
				$error("mid_distance: expected %0d, actual %0d", exp_r.mid_distance,
					got.mid_distance);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	seg_in_t pair;
	logic done;
	seg_out_t result;
	logic eps_valid;
	logic eps_ready;
	logic [EPS_W-1:0] eps_data;

	intersect_scoreboard sb;
	int cycles;
	bit idle_gaps;

	segment_pair_intersection_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pair(pair),
		.done(done),
		.result(result),
		.eps_valid(eps_valid),
		.eps_ready(eps_ready),
		.eps_data(eps_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	function automatic logic signed [31:0] q16(int v);
		return 32'(v) <<< 16;
	endfunction

	function automatic logic signed [31:0] near(int range_units);
		int span;
		span = range_units << 16;
		return $signed(32'($urandom_range(0, 2 * span))) - span;
	endfunction

	function automatic seg_in_t mk(logic signed [31:0] a0x, logic signed [31:0] a0y,
			logic signed [31:0] a1x, logic signed [31:0] a1y, logic signed [31:0] b0x,
			logic signed [31:0] b0y, logic signed [31:0] b1x, logic signed [31:0] b1y);
		seg_in_t p;
		p.a_start_x = a0x; p.a_start_y = a0y; p.a_end_x = a1x; p.a_end_y = a1y;
		p.b_start_x = b0x; p.b_start_y = b0y; p.b_end_x = b1x; p.b_end_y = b1y;
		return p;
	endfunction

	function automatic seg_in_t random_pair();
		seg_in_t p;
		logic signed [31:0] ox, oy, vx, vy, midx, midy;
		int mode;
		mode = $urandom_range(0, 9);
		p = mk(near(200), near(200), near(200), near(200),
			near(200), near(200), near(200), near(200));
		case (mode)
			0, 1: begin
				p = {$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom};
			end
			6: begin
				ox = near(50); oy = near(50);
				p.b_start_x = p.a_start_x + ox; p.b_start_y = p.a_start_y + oy;
				p.b_end_x = p.a_end_x + ox; p.b_end_y = p.a_end_y + oy;
			end
			7: begin
				if ($urandom_range(0, 1)) begin
					p.a_end_x = p.a_start_x; p.a_end_y = p.a_start_y;
				end else begin
					p.b_end_x = p.b_start_x; p.b_end_y = p.b_start_y;
				end
			end
			8: begin
				midx = (p.a_start_x >>> 1) + (p.a_end_x >>> 1);
				midy = (p.a_start_y >>> 1) + (p.a_end_y >>> 1);
				vx = near(100); vy = near(100);
				p.b_start_x = midx + vx; p.b_start_y = midy + vy;
				p.b_end_x = midx - vx; p.b_end_y = midy - vy;
			end
			9: begin
				p.a_end_x = p.a_start_x + near(300);
				p.a_end_y = p.a_start_y + $signed(32'($urandom_range(0, 6))) - 3;
				p.b_end_y = p.b_start_y + near(300);
				p.b_end_x = p.b_start_x + $signed(32'($urandom_range(0, 6))) - 3;
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic pause_sender();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (idle_gaps) begin
			if (r >= 90) n = $urandom_range(10, 40);
			else if (r >= 50) n = $urandom_range(1, 3);
		end
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_pair(seg_in_t p);
		start <= 1'b1;
		pair <= p;
		do @(posedge clk); while (busy);
		sb.note_pair(p);
		pause_sender();
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_crossings.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_eps(logic [EPS_W-1:0] v);
		drain();
		eps_valid <= 1'b1;
		eps_data <= v;
		do @(posedge clk); while (!eps_ready);
		eps_valid <= 1'b0;
		sb.eps = v;
	endtask

	task automatic directed_pairs();
		send_pair(mk(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(mk(0, 0, q16(10), q16(10), 0, q16(10), q16(10), 0));
		send_pair(mk(0, 0, q16(10), 0, 0, q16(2), q16(10), q16(2)));
		send_pair(mk(0, 0, q16(10), 0, q16(2), 0, q16(8), 0));
		send_pair(mk(0, 0, q16(4), 0, q16(4), -q16(3), q16(4), q16(3)));
		send_pair(mk(0, 0, q16(4), 0, 0, -q16(3), 0, q16(3)));
		send_pair(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
		send_pair(mk(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_pair(mk(0, 0, q16(1), 0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
			32'h80000001));
		send_pair(mk(0, 0, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFE,
			32'h7FFFFFFE));
		send_pair(mk(0, 0, q16(10), 1, q16(1000), q16(5), q16(1000), q16(6)));
		send_pair(mk(q16(1), q16(1), q16(3), q16(5), q16(7), q16(7), q16(7), q16(7)));
		send_pair(mk(q16(-5), q16(-5), q16(-1), q16(-1), q16(100), 0, q16(101), q16(-1)));
		send_pair(mk(0, 0, 32'h7FFFFFFF, 1, 32'h80000000, 32'h7FFFFFFF, 1,
			32'h80000000));
		send_pair(mk(q16(1), 0, 0, q16(1), 0, 0, q16(1), q16(1)));
	endtask

	initial begin
		logic [EPS_W-1:0] eps_plan[5];
		sb = new();
		cycles = 0;
		idle_gaps = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		pair = '0;
		eps_valid = 1'b0;
		eps_data = '0;
		eps_plan[0] = 16'd0;
		eps_plan[1] = 16'hFFFF;
		eps_plan[2] = EPS_RESET;
		eps_plan[3] = 16'd300;
		eps_plan[4] = 16'($urandom_range(2, 65534));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_pairs();
		for (int ph = 0; ph < 5; ph++) begin
			write_eps(eps_plan[ph]);
			if (ph == 1) directed_pairs();
			idle_gaps = (ph != 2);
			for (int i = 0; i < RAND_PER_PHASE; i++) send_pair(random_pair());
		end
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/spi_pkg.sv
rtl/core/segment_pair_intersection_top.sv
rtl/core/spi_chk.sv
bench/segment_pair_intersection_top_tb.sv
